// ===== src/qdla_pkg.sv =====
// Shared constants, opcode codes and the saturation helper for the
// quantised dense layer accumulator. No dependencies.
package qdla_pkg;

  localparam int NUM_INPUTS_DEF = 784;
  localparam int NUM_NODES_DEF  = 10;

  localparam int OP_W       = 2;
  localparam int INDEX_W    = 10;
  localparam int NODE_IDX_W = 4;
  localparam int WCODE_W    = 4;
  localparam int BIAS_W     = 16;
  localparam int STEP_W     = 4;
  localparam int ACT_W      = 18;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_WEIGHT = 2'd0,
    OP_LOAD_BIAS   = 2'd1,
    OP_FEED        = 2'd2
  } opcode_t;

  // Clamps a sum that is one bit wider than an activation to the signed range.
  function automatic logic signed [ACT_W-1:0] sat_act(input logic signed [ACT_W:0] v);
    logic signed [ACT_W-1:0] res;
    if (v[ACT_W] != v[ACT_W-1]) begin
      res = v[ACT_W] ? {1'b1, {(ACT_W-1){1'b0}}} : {1'b0, {(ACT_W-1){1'b1}}};
    end else begin
      res = v[ACT_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== src/qdla_if.sv =====
// Request and result channel interfaces of the quantised dense layer.
// Depends on qdla_pkg for the field widths.
interface qdla_in_if
  import qdla_pkg::*;
  ;
  logic                         valid;
  logic                         ready;
  logic [OP_W-1:0]              opcode;
  logic [INDEX_W-1:0]           input_index;
  logic [NODE_IDX_W-1:0]        node_index;
  logic signed [WCODE_W-1:0]    weight_code;
  logic signed [BIAS_W-1:0]     bias_value;
  logic [STEP_W-1:0]            activation_step;
  logic                         last_input;

  modport source (output valid, opcode, input_index, node_index, weight_code,
                  bias_value, activation_step, last_input, input ready);
  modport sink (input valid, opcode, input_index, node_index, weight_code,
                bias_value, activation_step, last_input, output ready);
endinterface

interface qdla_out_if
  import qdla_pkg::*;
  ;
  logic                      valid;
  logic                      ready;
  logic [NODE_IDX_W-1:0]     result_node;
  logic signed [ACT_W-1:0]   activation;
  logic                      last_result;

  modport source (output valid, result_node, activation, last_result, input ready);
  modport sink (input valid, result_node, activation, last_result, output ready);
endinterface

// ===== src/quantized_dense_layer_accumulate.sv =====
// Quantised dense layer: weight, bias and accumulator memories with a
// read-modify-write pass over the nodes. Depends on qdla_pkg and qdla_if.
//
//  channel  direction  handshake          content
//  in_ch    in         valid/ready        load weight, load bias or feed one input step
//  out_ch   out        valid/ready        one activation per node after the last input
//
// A load request writes its memory as it is taken. A feed request keeps the block busy
// until its node pass has drained: the node counter visits one node per cycle unless
// the output stalls, through the single read port of each memory, and a two-stage
// tail carries the multiply-accumulate and the bias add.
// Reset clears the sequencer, the pipeline valids and the accumulator valid bits; the
// weight and bias memories are not cleared. While the output register is held by a stalled
// sink the whole node pass halts; a new request is taken as soon as the pass has drained.
module quantized_dense_layer_accumulate
  import qdla_pkg::*;
#(
  parameter int NUM_INPUTS = NUM_INPUTS_DEF,
  parameter int NUM_NODES  = NUM_NODES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  qdla_in_if.sink    in_ch,
  qdla_out_if.source out_ch
);

  localparam int NODE_W = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
  localparam int WDEPTH = NUM_INPUTS * NUM_NODES;
  localparam int WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t                   state_r, state_nxt;
  logic [NODE_W-1:0]        cnt_r, cnt_nxt;
  logic [WA_W-1:0]          base_r;
  logic [STEP_W-1:0]        step_r;
  logic                     feed_ok_r;
  logic                     last_r;

  logic                     in_acc;
  opcode_t                  op;
  logic                     in_ok, node_ok;
  logic [WA_W-1:0]          w_addr_in;
  logic                     w_we, b_we;
  logic                     adv, issue, last_issue;

  logic signed [WCODE_W-1:0] wmem [WDEPTH];
  logic signed [BIAS_W-1:0]  bmem [NUM_NODES];
  logic signed [ACT_W-1:0]   amem [NUM_NODES];
  logic [NUM_NODES-1:0]      avld_r;

  logic signed [WCODE_W-1:0] w_rd_r;
  logic signed [BIAS_W-1:0]  b_rd_r;
  logic signed [ACT_W-1:0]   a_rd_r;
  logic                      a_rdv_r;

  logic                      s1_valid_r;
  logic [NODE_W-1:0]         s1_node_r;
  logic                      s1_lastnode_r;

  logic signed [STEP_W:0]            step_s;
  logic signed [STEP_W+WCODE_W:0]    prod;
  logic signed [ACT_W-1:0]           acc_cur, acc_sum;
  logic signed [ACT_W:0]             sum_wide, act_wide;

  logic                      s2_valid_r;
  logic signed [ACT_W-1:0]   s2_sum_r;
  logic signed [BIAS_W-1:0]  s2_bias_r;
  logic [NODE_W-1:0]         s2_node_r;
  logic                      s2_lastnode_r;

  logic                      out_valid_r;
  logic [NODE_IDX_W-1:0]     out_node_r;
  logic signed [ACT_W-1:0]   out_act_r;
  logic                      out_last_r;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign op          = opcode_t'(in_ch.opcode);
  assign in_ok       = int'(in_ch.input_index) < NUM_INPUTS;
  assign node_ok     = int'(in_ch.node_index) < NUM_NODES;
  assign w_addr_in   = WA_W'(int'(in_ch.input_index) * NUM_NODES + int'(in_ch.node_index));
  assign w_we        = in_acc && (op == OP_LOAD_WEIGHT) && in_ok && node_ok;
  assign b_we        = in_acc && (op == OP_LOAD_BIAS) && node_ok;

  // Everything downstream of the counter moves together, so a held output
  // register freezes the pass without losing a node.
  assign adv        = !out_valid_r || out_ch.ready;
  assign issue      = (state_r == ST_RUN) && adv;
  assign last_issue = (cnt_r == NODE_W'(NUM_NODES - 1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (op == OP_FEED)) begin
          state_nxt = ST_RUN;
          cnt_nxt   = '0;
        end
      end
      ST_RUN: begin
        if (issue) begin
          cnt_nxt = cnt_r + 1'b1;
          if (last_issue) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!s1_valid_r && !s2_valid_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (op == OP_FEED)) begin
      base_r    <= in_ok ? WA_W'(int'(in_ch.input_index) * NUM_NODES) : '0;
      step_r    <= in_ch.activation_step;
      feed_ok_r <= in_ok;
      last_r    <= in_ch.last_input;
    end
  end

  // Weight and bias memories: written by load requests, read by the node pass.
  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_addr_in] <= in_ch.weight_code;
    end
    if (issue) begin
      w_rd_r <= wmem[base_r + WA_W'(cnt_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      bmem[NODE_W'(in_ch.node_index)] <= in_ch.bias_value;
    end
    if (issue) begin
      b_rd_r <= bmem[cnt_r];
    end
  end

  // Accumulator memory. An entry that has not been written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (issue) begin
      a_rd_r <= amem[cnt_r];
    end
    if (adv && s1_valid_r) begin
      amem[s1_node_r] <= last_r ? '0 : acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avld_r  <= '0;
      a_rdv_r <= 1'b0;
    end else begin
      if (issue) begin
        a_rdv_r <= avld_r[cnt_r];
      end
      if (adv && s1_valid_r) begin
        avld_r[s1_node_r] <= 1'b1;
      end
    end
  end

  // Stage 1: multiply the step by the weight and add into the accumulator.
  assign step_s   = signed'({1'b0, step_r});
  assign prod     = step_s * w_rd_r;
  assign acc_cur  = a_rdv_r ? a_rd_r : '0;
  assign sum_wide = (ACT_W+1)'(acc_cur) + (ACT_W+1)'(prod);
  assign acc_sum  = feed_ok_r ? sat_act(sum_wide) : acc_cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= issue;
      s2_valid_r <= s1_valid_r && last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_node_r     <= cnt_r;
      s1_lastnode_r <= last_issue;
      s2_sum_r      <= acc_sum;
      s2_bias_r     <= b_rd_r;
      s2_node_r     <= s1_node_r;
      s2_lastnode_r <= s1_lastnode_r;
    end
  end

  // Stage 2: add the bias into the output register.
  assign act_wide = (ACT_W+1)'(s2_sum_r) + (ACT_W+1)'(s2_bias_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r) begin
      out_node_r <= NODE_IDX_W'(s2_node_r);
      out_act_r  <= sat_act(act_wide);
      out_last_r <= s2_lastnode_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_node = out_node_r;
  assign out_ch.activation  = out_act_r;
  assign out_ch.last_result = out_last_r;

endmodule

// ===== sim/quantized_dense_layer_accumulate_tb.sv =====
// Testbench for the quantised dense layer: a table of directed requests, then random
// loads and feeds, each result checked against an in-bench layer predictor.
// Depends on qdla_pkg, qdla_if and the quantized_dense_layer_accumulate RTL.
module quantized_dense_layer_accumulate_tb;
  import qdla_pkg::*;

  localparam int N_IN = NUM_INPUTS_DEF;
  localparam int N_NODES = NUM_NODES_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int ACT_HI = (1 <<< (ACT_W - 1)) - 1;
  localparam int ACT_LO = -(1 <<< (ACT_W - 1));
  localparam int RANDOM_REQS = 280;
  localparam int MAX_WAIT = 18;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DIR_ROWS = 17;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic [INDEX_W-1:0]        inp;
    logic [NODE_IDX_W-1:0]     node;
    logic signed [WCODE_W-1:0] wcode;
    logic signed [BIAS_W-1:0]  bias;
    logic [STEP_W-1:0]         step;
    logic                      last;
  } layer_req_t;

  typedef struct packed {
    logic [NODE_IDX_W-1:0]   node;
    logic signed [ACT_W-1:0] act;
    logic                    last;
  } node_act_t;

  // A row with every_node set expands into one request per node; typed rows carry the
  // activation that every node must report.
  typedef struct {
    int op;
    int inp;
    bit every_node;
    int node;
    int wcode;
    int bias;
    int step;
    bit last;
    int reps;
    bit typed;
    int act;
  } dir_row_t;

  dir_row_t directed_rows [DIR_ROWS] = '{
    //  op              inp   all node wcode bias    step last reps  typed act
    '{OP_LOAD_BIAS,    0,    1,  0,   0,    0,      0,   1,   1,    0,    0},
    '{OP_LOAD_WEIGHT,  0,    1,  0,   7,    0,      0,   0,   1,    0,    0},
    '{OP_LOAD_WEIGHT,  783,  1,  0,   -8,   0,      0,   0,   1,    0,    0},
    '{OP_FEED,         0,    0,  0,   0,    0,      0,   1,   1,    1,    0},
    '{OP_FEED,         0,    0,  0,   0,    0,      15,  1,   1,    1,    105},
    '{OP_FEED,         783,  0,  0,   0,    0,      15,  1,   1,    1,    -120},
    '{OP_UNUSED,       0,    0,  15,  -1,   -1,     15,  1,   1,    0,    0},
    '{OP_FEED,         1023, 0,  15,  -1,   -1,     15,  1,   1,    1,    0},
    '{OP_LOAD_WEIGHT,  1023, 0,  0,   -1,   0,      0,   0,   1,    0,    0},
    '{OP_LOAD_WEIGHT,  0,    0,  15,  -8,   0,      0,   1,   1,    0,    0},
    '{OP_LOAD_BIAS,    0,    0,  15,  0,    -1,     0,   1,   1,    0,    0},
    '{OP_FEED,         0,    0,  0,   0,    0,      15,  1,   1,    1,    105},
    '{OP_LOAD_BIAS,    0,    1,  0,   0,    32767,  0,   0,   1,    0,    0},
    '{OP_FEED,         0,    0,  0,   0,    0,      15,  1,   1,    0,    0},
    '{OP_LOAD_BIAS,    0,    1,  0,   0,    -32768, 0,   0,   1,    0,    0},
    '{OP_FEED,         783,  0,  0,   0,    0,      15,  1,   1,    0,    0},
    '{OP_LOAD_BIAS,    0,    1,  0,   0,    0,      0,   0,   1,    0,    0}
  };

  logic clk = 1'b0;
  logic rst_n;

  qdla_in_if in_ch ();
  qdla_out_if out_ch ();

  quantized_dense_layer_accumulate uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic signed [WCODE_W-1:0] weight_mem [N_IN*N_NODES];
  bit weight_known [N_IN*N_NODES];
  bit input_complete [N_IN];
  int loaded_inputs [$];
  logic signed [BIAS_W-1:0] bias_mem [N_NODES];
  logic signed [ACT_W-1:0] node_acc [N_NODES] = '{default: '0};
  node_act_t pending_acts [$];

  int errors = 0;
  int cycles = 0;
  bit src_quiet = 1'b0;
  bit sink_quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic signed [ACT_W-1:0] clamp_act(input int v);
    int c;
    c = (v > ACT_HI) ? ACT_HI : ((v < ACT_LO) ? ACT_LO : v);
    return c[ACT_W-1:0];
  endfunction

  function automatic int draw_wait(input bit quiet);
    return quiet ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  // Updates the layer state for one accepted request and queues the activations it causes.
  function automatic void predict_layer(input layer_req_t r, input bit typed,
                                        input int typed_act);
    int base;
    int n;
    int sum;
    bit full;
    node_act_t res;
    base = int'(r.inp) * N_NODES;
    if (r.op == OP_LOAD_WEIGHT) begin
      if (r.inp < N_IN && r.node < N_NODES) begin
        weight_mem[base + int'(r.node)] = r.wcode;
        weight_known[base + int'(r.node)] = 1'b1;
        full = 1'b1;
        for (n = 0; n < N_NODES; n++) full &= weight_known[base + n];
        if (full && !input_complete[r.inp]) begin
          input_complete[r.inp] = 1'b1;
          loaded_inputs.push_back(int'(r.inp));
        end
      end
    end else if (r.op == OP_LOAD_BIAS) begin
      if (r.node < N_NODES) bias_mem[r.node] = r.bias;
    end else if (r.op == OP_FEED) begin
      if (r.inp < N_IN) begin
        for (n = 0; n < N_NODES; n++) begin
          node_acc[n] = clamp_act(int'(node_acc[n]) +
                                  int'(r.step) * int'(weight_mem[base + n]));
        end
      end
      if (r.last) begin
        for (n = 0; n < N_NODES; n++) begin
          sum = int'(node_acc[n]) + int'(bias_mem[n]);
          res.node = NODE_IDX_W'(n);
          res.act = typed ? typed_act[ACT_W-1:0] : clamp_act(sum);
          res.last = (n == N_NODES - 1);
          pending_acts.push_back(res);
          node_acc[n] = '0;
        end
      end
    end
  endfunction

  function automatic layer_req_t noise_req();
    layer_req_t r;
    r.op = OP_W'($urandom);
    r.inp = INDEX_W'($urandom);
    r.node = NODE_IDX_W'($urandom);
    r.wcode = WCODE_W'($urandom);
    r.bias = BIAS_W'($urandom);
    r.step = STEP_W'($urandom);
    r.last = 1'($urandom);
    return r;
  endfunction

  task automatic send_request(input layer_req_t r, input bit typed, input int typed_act);
    int gap;
    if ($urandom_range(0, 29) == 0) src_quiet = !src_quiet;
    gap = draw_wait(src_quiet);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= r.op;
    in_ch.input_index <= r.inp;
    in_ch.node_index <= r.node;
    in_ch.weight_code <= r.wcode;
    in_ch.bias_value <= r.bias;
    in_ch.activation_step <= r.step;
    in_ch.last_input <= r.last;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    predict_layer(r, typed, typed_act);
  endtask

  initial begin : result_side
    int stall;
    node_act_t want;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) sink_quiet = !sink_quiet;
      stall = draw_wait(sink_quiet);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
      if (pending_acts.size() == 0) begin
        $error("activation for node %0d with nothing expected", out_ch.result_node);
        errors++;
      end else begin
        want = pending_acts.pop_front();
        if (out_ch.result_node !== want.node) begin
          $error("result_node: expected %0d, got %0d", want.node, out_ch.result_node);
          errors++;
        end
        if (out_ch.activation !== want.act) begin
          $error("activation: expected %0d, got %0d", want.act, out_ch.activation);
          errors++;
        end
        if (out_ch.last_result !== want.last) begin
          $error("last_result: expected %0d, got %0d", want.last, out_ch.last_result);
          errors++;
        end
      end
    end
  end

  initial begin : request_side
    layer_req_t r;
    int i;
    int rep;
    int n;
    int first_node;
    int last_node;
    int pick;
    int inp;
    int tries;
    int counted;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= '0;
    in_ch.input_index <= '0;
    in_ch.node_index <= '0;
    in_ch.weight_code <= '0;
    in_ch.bias_value <= '0;
    in_ch.activation_step <= '0;
    in_ch.last_input <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < DIR_ROWS; i++) begin
      first_node = directed_rows[i].every_node ? 0 : directed_rows[i].node;
      last_node = directed_rows[i].every_node ? N_NODES - 1 : directed_rows[i].node;
      for (rep = 0; rep < directed_rows[i].reps; rep++) begin
        for (n = first_node; n <= last_node; n++) begin
          r.op = OP_W'(directed_rows[i].op);
          r.inp = INDEX_W'(directed_rows[i].inp);
          r.node = NODE_IDX_W'(n);
          r.wcode = WCODE_W'(directed_rows[i].wcode);
          r.bias = BIAS_W'(directed_rows[i].bias);
          r.step = STEP_W'(directed_rows[i].step);
          r.last = directed_rows[i].last;
          send_request(r, directed_rows[i].typed, directed_rows[i].act);
        end
      end
    end

    // Feeds in range only address inputs whose ten weights are all loaded; out-of-range
    // feeds still count; ignored requests are mixed in as noise and do not count.
    counted = 0;
    while (counted < RANDOM_REQS) begin
      r = noise_req();
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        inp = $urandom_range(0, N_IN - 1);
        for (tries = 0; tries < 20 && input_complete[inp]; tries++) begin
          inp = $urandom_range(0, N_IN - 1);
        end
        for (n = 0; n < N_NODES; n++) begin
          r = noise_req();
          r.op = OP_LOAD_WEIGHT;
          r.inp = INDEX_W'(inp);
          r.node = NODE_IDX_W'(n);
          send_request(r, 1'b0, 0);
        end
        counted += N_NODES;
      end else begin
        if (pick < 18) begin
          r.op = OP_LOAD_WEIGHT;
          r.inp = INDEX_W'(loaded_inputs[$urandom_range(0, loaded_inputs.size() - 1)]);
          r.node = NODE_IDX_W'($urandom_range(0, N_NODES - 1));
          counted++;
        end else if (pick < 24) begin
          r.op = OP_LOAD_BIAS;
          if (r.node < N_NODES) counted++;
        end else if (pick < 28) begin
          r.op = OP_LOAD_WEIGHT;
          if ($urandom_range(0, 1) == 1) begin
            r.inp = INDEX_W'($urandom_range(N_IN, (1 << INDEX_W) - 1));
          end else begin
            r.node = NODE_IDX_W'($urandom_range(N_NODES, (1 << NODE_IDX_W) - 1));
          end
        end else if (pick < 31) begin
          r.op = OP_UNUSED;
        end else if (pick < 37) begin
          r.op = OP_FEED;
          r.inp = INDEX_W'($urandom_range(N_IN, (1 << INDEX_W) - 1));
          r.last = ($urandom_range(0, 7) == 0);
          counted++;
        end else begin
          r.op = OP_FEED;
          r.inp = INDEX_W'(loaded_inputs[$urandom_range(0, loaded_inputs.size() - 1)]);
          r.last = ($urandom_range(0, 7) == 0);
          counted++;
        end
        send_request(r, 1'b0, 0);
      end
    end

    // Close the open vector so that every accumulated step is seen in a result.
    r = noise_req();
    r.op = OP_FEED;
    r.inp = INDEX_W'(loaded_inputs[0]);
    r.last = 1'b1;
    send_request(r, 1'b0, 0);
    in_ch.valid <= 1'b0;

    while (pending_acts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== quantized_dense_layer_accumulate.f =====
src/qdla_pkg.sv
src/qdla_if.sv
src/quantized_dense_layer_accumulate.sv
sim/quantized_dense_layer_accumulate_tb.sv
